[hdl/lpmms_pkg.sv]
// Shared types and constants for the linear partition min-max-sum block.
// Holds the transaction payload structs and the configuration register map.
// No dependencies.
`default_nettype none

package lpmms_pkg;

   localparam int WEIGHT_BITS = 16;
   localparam int RESULT_BITS = 22;
   localparam int PART_BITS   = 5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index, taken from paddr[2] (one 32-bit register per word).
   localparam logic CSR_IDX_PART_COUNT = 1'b0;

   localparam logic [PART_BITS-1:0] PART_COUNT_RESET = PART_BITS'(1);

   typedef struct packed {
      logic [WEIGHT_BITS-1:0] weight;
      logic                   last;
   } req_type;

   typedef struct packed {
      logic [RESULT_BITS-1:0] min_max_sum;
      logic                   overflow;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/linear_partition_min_max_sum.sv]
// Linear partition solver: splits a weight sequence into at most part_count
// contiguous groups and reports the smallest achievable largest group sum.
// Depends on lpmms_pkg for payload types and the register map.
//
//   Port group    Direction  Handshake          Contents
//   req_*         in         req_valid/ready    weight, last (lpmms_pkg::req_type)
//   rsp_*         out        rsp_valid/ready    min_max_sum, overflow (rsp_type)
//   APB           in/out     psel/penable       part_count at byte address 0
//
// A weight is taken whenever req_valid and req_ready are both high. The last transaction
// starts the solver, which walks rows 2..k and columns 2..n through one subtract/max/min
// datapath with one read port on each store; the result enters the output register once
// that register is free. req_ready is low while solving. One result waits in the output
// register while input goes on; a second holds req_ready low until rsp_ready.
// Reset is synchronous.
`default_nettype none

module linear_partition_min_max_sum #(
   parameter int MAX_ITEMS = 64,
   parameter int MAX_PARTS = 16
) (
   input  wire                                clock,
   input  wire                                reset,

   input  wire                                req_valid,
   output logic                               req_ready,
   input  lpmms_pkg::req_type                 req_payload,

   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output lpmms_pkg::rsp_type                 rsp_payload,

   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire  [lpmms_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire  [lpmms_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lpmms_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                               pready
);

   localparam int CW    = $clog2(MAX_ITEMS + 1);
   localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int KW    = (MAX_PARTS > 1) ? $clog2(MAX_PARTS + 1) : 1;
   localparam int SUM_W = lpmms_pkg::WEIGHT_BITS + $clog2(MAX_ITEMS);
   localparam int EXT_W = (SUM_W > lpmms_pkg::RESULT_BITS) ? SUM_W
                                                           : lpmms_pkg::RESULT_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ROW,
      ST_JREAD,
      ST_JWAIT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W-1:0]    first_ff, first_in;
   logic [lpmms_pkg::PART_BITS-1:0] part_ff, part_in;
   logic [CW-1:0]       n_ff, n_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [KW-1:0]       i_ff, i_in;
   logic [CW-1:0]       j_ff, j_in;
   logic [CW-1:0]       p_ff, p_in;
   logic [SUM_W-1:0]    pj_ff, pj_in;
   logic [SUM_W-1:0]    best_ff, best_in;
   logic [SUM_W-1:0]    m_ff, m_in;
   logic                rdv_ff, rdv_in;
   logic                mv_ff, mv_in;
   logic [SUM_W-1:0]    res_ff, res_in;
   logic                res_ovf_ff, res_ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   lpmms_pkg::rsp_type  rsp_ff, rsp_in;

   // Prefix store: entry a holds the sum of the first a+1 weights.
   logic [SUM_W-1:0]    pre_mem [MAX_ITEMS];
   logic [SUM_W-1:0]    pre_rd_ff;
   // Two cost rows, entry a of a row holds the cost for the first a+1 items.
   logic [SUM_W-1:0]    cost_mem [2][MAX_ITEMS];
   logic [SUM_W-1:0]    cost_rd_ff;

   logic                pre_we;
   logic [AW-1:0]       pre_waddr;
   logic [SUM_W-1:0]    pre_wdata;
   logic                cost_we;
   logic                cost_wbank;
   logic [AW-1:0]       cost_waddr;
   logic [SUM_W-1:0]    cost_wdata;
   logic [AW-1:0]       rd_addr;
   logic                cost_rbank;

   logic                req_fire;
   logic                csr_write;
   logic [KW-1:0]       k_sat;
   logic [SUM_W-1:0]    load_sum;
   logic [SUM_W-1:0]    tail;
   logic [SUM_W-1:0]    src;
   logic [EXT_W-1:0]    res_ext;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign pready      = 1'b1;
   assign csr_write   = psel && penable && pwrite && pready &&
                        (paddr[2] == lpmms_pkg::CSR_IDX_PART_COUNT);

   always_comb begin
      if (paddr[2] == lpmms_pkg::CSR_IDX_PART_COUNT) begin
         prdata = lpmms_pkg::CSR_DATA_W'(part_ff);
      end else begin
         prdata = '0;
      end
   end

   // Part count zero behaves as one; large counts saturate.
   always_comb begin
      if (part_ff == '0) begin
         k_sat = KW'(1);
      end else if (32'(part_ff) > 32'(MAX_PARTS)) begin
         k_sat = KW'(MAX_PARTS);
      end else begin
         k_sat = KW'(part_ff);
      end
   end

   assign load_sum = sum_ff + SUM_W'(req_payload.weight);
   assign tail     = pj_ff - pre_rd_ff;
   assign src      = (i_ff == KW'(2)) ? pre_rd_ff : cost_rd_ff;
   assign res_ext  = EXT_W'(res_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      sum_in       = sum_ff;
      first_in     = first_ff;
      part_in      = part_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      p_in         = p_ff;
      pj_in        = pj_ff;
      best_in      = best_ff;
      m_in         = m_ff;
      rdv_in       = 1'b0;
      mv_in        = 1'b0;
      res_in       = res_ff;
      res_ovf_in   = res_ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      pre_we       = 1'b0;
      pre_waddr    = AW'(count_ff);
      pre_wdata    = load_sum;
      cost_we      = 1'b0;
      cost_wbank   = i_ff[0];
      cost_waddr   = AW'(j_ff - CW'(1));
      cost_wdata   = best_ff;
      rd_addr      = AW'(j_ff - CW'(1));
      cost_rbank   = ~i_ff[0];

      if (csr_write) begin
         part_in = pwdata[lpmms_pkg::PART_BITS-1:0];
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (32'(count_ff) < 32'(MAX_ITEMS)) begin
                  pre_we   = 1'b1;
                  sum_in   = load_sum;
                  count_in = count_ff + CW'(1);
                  if (count_ff == '0) begin
                     first_in = load_sum;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_payload.last) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            n_in       = count_ff;
            k_in       = k_sat;
            res_ovf_in = ovf_ff;
            count_in   = '0;
            ovf_in     = 1'b0;
            sum_in     = '0;
            // One part or one item: the answer is the whole sum.
            if (count_ff == CW'(1) || k_sat == KW'(1)) begin
               res_in   = sum_ff;
               state_in = ST_FINISH;
            end else begin
               i_in     = KW'(2);
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            cost_we    = 1'b1;
            cost_waddr = '0;
            cost_wdata = first_ff;
            j_in       = CW'(2);
            state_in   = ST_JREAD;
         end
         ST_JREAD: begin
            state_in = ST_JWAIT;
         end
         ST_JWAIT: begin
            pj_in    = pre_rd_ff;
            best_in  = '1;
            rd_addr  = '0;
            rdv_in   = 1'b1;
            p_in     = CW'(2);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Issue one split point per cycle; two stages behind, fold into best.
            if (p_ff < j_ff) begin
               rd_addr = AW'(p_ff - CW'(1));
               rdv_in  = 1'b1;
               p_in    = p_ff + CW'(1);
            end
            if (rdv_ff) begin
               m_in  = (tail > src) ? tail : src;
               mv_in = 1'b1;
            end
            if (mv_ff && (m_ff < best_ff)) begin
               best_in = m_ff;
            end
            if ((p_ff == j_ff) && !rdv_ff && !mv_ff) begin
               cost_we = 1'b1;
               if (j_ff == n_ff) begin
                  if (i_ff == k_ff) begin
                     res_in   = best_ff;
                     state_in = ST_FINISH;
                  end else begin
                     i_in     = i_ff + KW'(1);
                     state_in = ST_ROW;
                  end
               end else begin
                  j_in     = j_ff + CW'(1);
                  state_in = ST_JREAD;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.min_max_sum = res_ext[lpmms_pkg::RESULT_BITS-1:0];
               rsp_in.overflow    = res_ovf_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sum_ff       <= '0;
         part_ff      <= lpmms_pkg::PART_COUNT_RESET;
         rdv_ff       <= 1'b0;
         mv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         sum_ff       <= sum_in;
         part_ff      <= part_in;
         rdv_ff       <= rdv_in;
         mv_ff        <= mv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      first_ff   <= first_in;
      n_ff       <= n_in;
      k_ff       <= k_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      p_ff       <= p_in;
      pj_ff      <= pj_in;
      best_ff    <= best_in;
      m_ff       <= m_in;
      res_ff     <= res_in;
      res_ovf_ff <= res_ovf_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (pre_we) begin
         pre_mem[pre_waddr] <= pre_wdata;
      end
      pre_rd_ff <= pre_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[cost_wbank][cost_waddr] <= cost_wdata;
      end
      cost_rd_ff <= cost_mem[cost_rbank][rd_addr];
   end

   // The last transaction of a sequence must close the input while solving.
   a_last_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_payload.last) |=> !req_ready)
      else $error("input still open after the last transaction");

   // Dropped items are only flagged once the prefix store is full.
   a_overflow_when_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (32'(count_ff) == 32'(MAX_ITEMS)))
      else $error("overflow flagged before the store filled");

   // Split point and column stay within the current sequence.
   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((p_ff <= j_ff) && (j_ff <= n_ff)))
      else $error("scan counters out of range");

   // A new result only comes out of the finish step.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finish step");

endmodule

`default_nettype wire
